>>> sv/sapf_pkg.sv
`timescale 1ns / 1ps

package sapf_pkg;

    // Default build values.
    localparam int COUNTER_PERIOD_DEF = 59999;
    localparam int FILTER_ORDER_DEF   = 3;

    // Field and datapath widths.
    localparam int ANGLE_W    = 9;
    localparam int PULSE_W    = 16;
    localparam int COEF_W     = 20;
    localparam int CFG_ADDR_W = 3;
    localparam int TDATA_W    = 16;
    localparam int SP_W       = 18;
    localparam int Y_W        = 34;
    localparam int PROD_W     = COEF_W + Y_W;
    localparam int ACC_W      = 56;
    localparam int MAG_W      = 25;
    localparam int REM_W      = 8;
    localparam int FRAC_W     = 16;

    // Angle mapping divisor (degrees over the full swing).
    localparam int MapDivisor = 180;

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MIN     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_MAX     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_B_OUTER  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_B_INNER  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_A_FIRST  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_A_SECOND = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_A_THIRD  = 3'd6;

    // Register values after reset.
    localparam logic [PULSE_W-1:0]       PULSE_MIN_RST     = 16'd1500;
    localparam logic [PULSE_W-1:0]       PULSE_MAX_RST     = 16'd7500;
    localparam logic signed [COEF_W-1:0] COEF_B_OUTER_RST  = 20'sd190;
    localparam logic signed [COEF_W-1:0] COEF_B_INNER_RST  = 20'sd570;
    localparam logic signed [COEF_W-1:0] COEF_A_FIRST_RST  = -20'sd155589;
    localparam logic signed [COEF_W-1:0] COEF_A_SECOND_RST = 20'sd126445;
    localparam logic signed [COEF_W-1:0] COEF_A_THIRD_RST  = -20'sd34872;

endpackage

>>> sv/servo_angle_to_filtered_pulse.sv
`timescale 1ns / 1ps

// Channel   Port group                     Word contents
// --------  -----------------------------  ------------------------------------
// input     s_tvalid / s_tready / s_tdata  angle_deg [8:0], signed degrees
// output    m_tvalid / m_tready / m_tdata  pulse_compare [15:0], unsigned
// config    cfg_we / cfg_addr / cfg_wdata  register index 0..6, write only
//
// A word passes through the bit-serial datapath in this order: the angle
// product, the divide by 180, saturation of the set point, then for each of
// the N+1 numerator and N denominator taps, N being FILTER_ORDER, a load,
// one step per data bit (18 for input history, 34 for output history) and
// an accumulate, then the floor of the sum and the registered result.
// A new word is accepted only while the unit is idle; a finished result waits
// in the output register, so the next word may enter before it is taken.
// Reset clears the filter history and loads the default register values.

module servo_angle_to_filtered_pulse
    import sapf_pkg::*;
#(
    parameter int COUNTER_PERIOD = COUNTER_PERIOD_DEF,
    parameter int FILTER_ORDER   = FILTER_ORDER_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TDATA_W-1:0]    s_tdata,    // [8:0] angle_deg, [15:9] zero
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [TDATA_W-1:0]    m_tdata,    // [15:0] pulse_compare
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [COEF_W-1:0]     cfg_wdata
);

    localparam int TERMS  = 2 * FILTER_ORDER + 1;
    localparam int TERM_W = $clog2(TERMS);
    localparam int HIST_W = (FILTER_ORDER > 1) ? $clog2(FILTER_ORDER) : 1;
    localparam int CNT_W  = 6;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL  = 4'd1;
    localparam logic [3:0] ST_DIV  = 4'd2;
    localparam logic [3:0] ST_MAP  = 4'd3;
    localparam logic [3:0] ST_LOAD = 4'd4;
    localparam logic [3:0] ST_MAC  = 4'd5;
    localparam logic [3:0] ST_ACC  = 4'd6;
    localparam logic [3:0] ST_SAT  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam logic [TERM_W-1:0] LAST_B_TERM = TERM_W'(FILTER_ORDER);
    localparam logic [TERM_W-1:0] LAST_TERM   = TERM_W'(TERMS - 1);
    localparam logic [SP_W:0]     PERIOD_Q    = (SP_W + 1)'(COUNTER_PERIOD);

    // Configuration registers.
    logic [PULSE_W-1:0]       pulse_min_reg;
    logic [PULSE_W-1:0]       pulse_max_reg;
    logic signed [COEF_W-1:0] coef_b_outer_reg;
    logic signed [COEF_W-1:0] coef_b_inner_reg;
    logic signed [COEF_W-1:0] coef_a_first_reg;
    logic signed [COEF_W-1:0] coef_a_second_reg;
    logic signed [COEF_W-1:0] coef_a_third_reg;

    // Control.
    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic              m_tvalid_reg, m_tvalid_next;

    // Filter history.
    logic signed [SP_W-1:0] in_hist_reg  [FILTER_ORDER];
    logic signed [Y_W-1:0]  out_hist_reg [FILTER_ORDER];
    logic                   hist_shift;

    // Datapath.
    logic                     neg_reg, neg_next;
    logic [ANGLE_W-1:0]       angle_sr_reg, angle_sr_next;
    logic [PULSE_W-1:0]       span_mag_reg, span_mag_next;
    logic [MAG_W-1:0]         mag_reg, mag_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic signed [SP_W-1:0]   sp_reg, sp_next;
    logic [Y_W-1:0]           data_sr_reg, data_sr_next;
    logic signed [COEF_W-1:0] coef_reg, coef_next;
    logic                     first_reg, first_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [Y_W-1:0]    y_reg, y_next;
    logic [TDATA_W-1:0]       m_tdata_reg, m_tdata_next;

    // Intermediate terms.
    logic                       accept;
    logic signed [ANGLE_W-1:0]  angle;
    logic signed [PULSE_W:0]    span;
    logic [REM_W:0]             trial;
    logic                       trial_ge;
    logic signed [SP_W+1:0]     quot_s;
    logic signed [SP_W+1:0]     mapped;
    logic                       is_b;
    logic [TERM_W-1:0]          a_k;
    logic [TERM_W-1:0]          hist_full;
    logic [HIST_W-1:0]          hist_idx;
    logic signed [PROD_W-1:0]   addend;
    logic signed [ACC_W-1:0]    acc_term;
    logic signed [ACC_W-FRAC_W-1:0] acc_floor;
    logic [SP_W:0]              y_int;
    logic                       out_free;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign angle = signed'(s_tdata[ANGLE_W-1:0]);
    assign span  = signed'({1'b0, pulse_max_reg}) - signed'({1'b0, pulse_min_reg});

    // Restoring divide step: one quotient bit per cycle.
    assign trial    = {rem_reg, mag_reg[MAG_W-1]};
    assign trial_ge = (trial >= (REM_W + 1)'(MapDivisor));

    // Signed quotient plus offset; the quotient is below 2^18.
    assign quot_s = neg_reg ? -signed'({2'b00, mag_reg[SP_W-1:0]})
                            :  signed'({2'b00, mag_reg[SP_W-1:0]});
    assign mapped = quot_s + signed'({4'b0000, pulse_min_reg});

    // Tap selection: numerator taps first, then denominator taps.
    assign is_b      = (term_reg <= LAST_B_TERM);
    assign a_k       = term_reg - LAST_B_TERM;
    assign hist_full = is_b ? (term_reg - TERM_W'(1)) : (a_k - TERM_W'(1));
    assign hist_idx  = HIST_W'(hist_full);

    // Horner step: the sign bit of the data weighs negative.
    assign addend = data_sr_reg[Y_W-1] ? PROD_W'(coef_reg) : '0;

    assign acc_term  = is_b ? (ACC_W'(prod_reg) <<< FRAC_W) : -ACC_W'(prod_reg);
    assign acc_floor = acc_reg[ACC_W-1:FRAC_W];

    // Integer part of a non-negative output; it is clamped to the counter period on output.
    assign y_int = {2'b00, y_reg[Y_W-2:FRAC_W]};

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        term_next     = term_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        hist_shift    = 1'b0;
        neg_next      = neg_reg;
        angle_sr_next = angle_sr_reg;
        span_mag_next = span_mag_reg;
        mag_next      = mag_reg;
        rem_next      = rem_reg;
        sp_next       = sp_reg;
        data_sr_next  = data_sr_reg;
        coef_next     = coef_reg;
        first_next    = first_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        y_next        = y_reg;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    angle_sr_next = angle[ANGLE_W-1] ? ANGLE_W'(-angle) : ANGLE_W'(angle);
                    span_mag_next = span[PULSE_W] ? PULSE_W'(-span) : PULSE_W'(span);
                    neg_next      = angle[ANGLE_W-1] ^ span[PULSE_W];
                    mag_next      = '0;
                    cnt_next      = CNT_W'(ANGLE_W - 1);
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                mag_next = (mag_reg << 1)
                         + (angle_sr_reg[ANGLE_W-1] ? MAG_W'(span_mag_reg) : '0);
                angle_sr_next = angle_sr_reg << 1;
                cnt_next      = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    rem_next   = '0;
                    cnt_next   = CNT_W'(MAG_W - 1);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_next = trial_ge ? REM_W'(trial - (REM_W + 1)'(MapDivisor))
                                    : REM_W'(trial);
                mag_next = {mag_reg[MAG_W-2:0], trial_ge};
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_MAP;
                end
            end
            ST_MAP:
            begin
                // Saturate the set point to the 18-bit signed range.
                if (mapped[SP_W+1:SP_W-1] == 3'b000 || mapped[SP_W+1:SP_W-1] == 3'b111)
                begin
                    sp_next = mapped[SP_W-1:0];
                end
                else
                begin
                    sp_next = mapped[SP_W+1] ? {1'b1, {(SP_W-1){1'b0}}}
                                             : {1'b0, {(SP_W-1){1'b1}}};
                end
                acc_next   = '0;
                term_next  = '0;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (is_b)
                begin
                    coef_next = (term_reg == '0 || term_reg == LAST_B_TERM)
                              ? coef_b_outer_reg : coef_b_inner_reg;
                    data_sr_next = (term_reg == '0) ? {sp_reg, {(Y_W-SP_W){1'b0}}}
                                 : {in_hist_reg[hist_idx], {(Y_W-SP_W){1'b0}}};
                    cnt_next = CNT_W'(SP_W - 1);
                end
                else
                begin
                    if (a_k == TERM_W'(1))
                    begin
                        coef_next = coef_a_first_reg;
                    end
                    else if (a_k == TERM_W'(2))
                    begin
                        coef_next = coef_a_second_reg;
                    end
                    else if (a_k == TERM_W'(3))
                    begin
                        coef_next = coef_a_third_reg;
                    end
                    else
                    begin
                        coef_next = '0;
                    end
                    data_sr_next = out_hist_reg[hist_idx];
                    cnt_next     = CNT_W'(Y_W - 1);
                end
                prod_next  = '0;
                first_next = 1'b1;
                state_next = ST_MAC;
            end
            ST_MAC:
            begin
                prod_next    = (prod_reg <<< 1) + (first_reg ? -addend : addend);
                data_sr_next = data_sr_reg << 1;
                first_next   = 1'b0;
                cnt_next     = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_next = acc_reg + acc_term;
                if (term_reg == LAST_TERM)
                begin
                    state_next = ST_SAT;
                end
                else
                begin
                    term_next  = term_reg + TERM_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_SAT:
            begin
                // Floor by 2^16, then saturate to the 34-bit signed range.
                if (acc_floor[ACC_W-FRAC_W-1:Y_W-1] == '0
                    || acc_floor[ACC_W-FRAC_W-1:Y_W-1] == '1)
                begin
                    y_next = acc_floor[Y_W-1:0];
                end
                else
                begin
                    y_next = acc_floor[ACC_W-FRAC_W-1] ? {1'b1, {(Y_W-1){1'b0}}}
                                                       : {1'b0, {(Y_W-1){1'b1}}};
                end
                hist_shift = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    if (y_reg[Y_W-1])
                    begin
                        m_tdata_next = '0;
                    end
                    else if (y_int > PERIOD_Q)
                    begin
                        m_tdata_next = TDATA_W'(PERIOD_Q);
                    end
                    else
                    begin
                        m_tdata_next = TDATA_W'(y_int);
                    end
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration registers and filter history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            cnt_reg           <= '0;
            term_reg          <= '0;
            m_tvalid_reg      <= 1'b0;
            pulse_min_reg     <= PULSE_MIN_RST;
            pulse_max_reg     <= PULSE_MAX_RST;
            coef_b_outer_reg  <= COEF_B_OUTER_RST;
            coef_b_inner_reg  <= COEF_B_INNER_RST;
            coef_a_first_reg  <= COEF_A_FIRST_RST;
            coef_a_second_reg <= COEF_A_SECOND_RST;
            coef_a_third_reg  <= COEF_A_THIRD_RST;
            for (int k = 0; k < FILTER_ORDER; k++)
            begin
                in_hist_reg[k]  <= '0;
                out_hist_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            term_reg     <= term_next;
            m_tvalid_reg <= m_tvalid_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_PULSE_MIN:     pulse_min_reg     <= cfg_wdata[PULSE_W-1:0];
                    REG_PULSE_MAX:     pulse_max_reg     <= cfg_wdata[PULSE_W-1:0];
                    REG_COEF_B_OUTER:  coef_b_outer_reg  <= cfg_wdata;
                    REG_COEF_B_INNER:  coef_b_inner_reg  <= cfg_wdata;
                    REG_COEF_A_FIRST:  coef_a_first_reg  <= cfg_wdata;
                    REG_COEF_A_SECOND: coef_a_second_reg <= cfg_wdata;
                    REG_COEF_A_THIRD:  coef_a_third_reg  <= cfg_wdata;
                    default:           ;
                endcase
            end

            // History moves by one place when a result is formed.
            if (hist_shift)
            begin
                for (int k = FILTER_ORDER - 1; k > 0; k--)
                begin
                    in_hist_reg[k]  <= in_hist_reg[k-1];
                    out_hist_reg[k] <= out_hist_reg[k-1];
                end
                in_hist_reg[0]  <= sp_reg;
                out_hist_reg[0] <= y_next;
            end
        end
    end

    // Working registers of the serial datapath.
    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        angle_sr_reg <= angle_sr_next;
        span_mag_reg <= span_mag_next;
        mag_reg      <= mag_next;
        rem_reg      <= rem_next;
        sp_reg       <= sp_next;
        data_sr_reg  <= data_sr_next;
        coef_reg     <= coef_next;
        first_reg    <= first_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        y_reg        <= y_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

>>> sv/sapf_check.sv
`timescale 1ns / 1ps

module sapf_check
    import sapf_pkg::*;
#(
    parameter int COUNTER_PERIOD = COUNTER_PERIOD_DEF
)
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata
);

    // A stalled result word holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word changed while stalled");

    // Every result lies within the counter period.
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata <= TDATA_W'(COUNTER_PERIOD))
        else $error("output word above counter period");

    // The unit is busy right after it takes a word.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while busy");

    // A result never appears in the cycle after an input word is taken.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

endmodule

bind servo_angle_to_filtered_pulse sapf_check #(
    .COUNTER_PERIOD(COUNTER_PERIOD)
) u_sapf_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> verif/tb_servo_angle_to_filtered_pulse.sv
`timescale 1ns / 1ps

module tb_servo_angle_to_filtered_pulse;

    import sapf_pkg::*;

    // Cycles without any accepted word before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 5000;
    // Cycles allowed for a word still in flight once the queue is empty.
    localparam int DRAIN_CYCLES   = 300;
    // Index past the last register; writes to it must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    // Saturation limits of the set point and of the stored filter output.
    localparam longint SP_HI = (longint'(1) <<< (SP_W - 1)) - 1;
    localparam longint SP_LO = -(longint'(1) <<< (SP_W - 1));
    localparam longint Y_HI  = (longint'(1) <<< (Y_W - 1)) - 1;
    localparam longint Y_LO  = -(longint'(1) <<< (Y_W - 1));

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata = '0;      // [8:0] angle_deg, [15:9] zero
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;           // [15:0] pulse_compare
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [COEF_W-1:0]     cfg_wdata = '0;

    // Copy of the register file as the block should hold it.
    logic [PULSE_W-1:0]       min_setting = PULSE_MIN_RST;
    logic [PULSE_W-1:0]       max_setting = PULSE_MAX_RST;
    logic signed [COEF_W-1:0] b_outer     = COEF_B_OUTER_RST;
    logic signed [COEF_W-1:0] b_inner     = COEF_B_INNER_RST;
    logic signed [COEF_W-1:0] a_first     = COEF_A_FIRST_RST;
    logic signed [COEF_W-1:0] a_second    = COEF_A_SECOND_RST;
    logic signed [COEF_W-1:0] a_third     = COEF_A_THIRD_RST;

    // Filter history: past set points and past filtered values (filtered values in Q.16).
    logic signed [SP_W-1:0] setpoint_hist [FILTER_ORDER_DEF];
    logic signed [Y_W-1:0]  filtered_hist [FILTER_ORDER_DEF];

    logic [PULSE_W-1:0] pulse_expected_q [$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int stall_left     = 0;
    bit gaps_on        = 1'b1;
    bit stalls_on      = 1'b1;

    servo_angle_to_filtered_pulse dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap(input bit enabled);
        int r;
        if (!enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // Mostly within the servo's swing, sometimes any 9 bit pattern.
    function automatic logic signed [ANGLE_W-1:0] pick_angle();
        if ($urandom_range(0, 4) == 0)
            return ANGLE_W'($urandom_range(0, 511));
        return ANGLE_W'($urandom_range(0, 360) - 180);
    endfunction

    // Advances the filter by one set point and returns the compare value.
    function automatic logic [PULSE_W-1:0] next_pulse_compare(
        input logic signed [ANGLE_W-1:0] angle
    );
        longint sp, acc, y, ipart, b_tap, a_tap, u;
        int     k;
        sp = (longint'(angle) * (longint'(max_setting) - longint'(min_setting)))
             / MapDivisor + longint'(min_setting);
        sp = (sp > SP_HI) ? SP_HI : ((sp < SP_LO) ? SP_LO : sp);

        // Difference equation; the numerator is symmetric.
        acc = 0;
        for (k = 0; k <= FILTER_ORDER_DEF; k++)
        begin
            b_tap = (k == 0 || k == FILTER_ORDER_DEF) ? longint'(b_outer)
                                                      : longint'(b_inner);
            u     = (k == 0) ? sp : longint'(setpoint_hist[k - 1]);
            acc   = acc + ((b_tap * u) <<< FRAC_W);
            if (k > 0)
            begin
                case (k)
                    1:       a_tap = longint'(a_first);
                    2:       a_tap = longint'(a_second);
                    3:       a_tap = longint'(a_third);
                    default: a_tap = 0;
                endcase
                acc = acc - a_tap * longint'(filtered_hist[k - 1]);
            end
        end

        // Floor back to Q.16 and saturate to the stored width.
        y = acc >>> FRAC_W;
        y = (y > Y_HI) ? Y_HI : ((y < Y_LO) ? Y_LO : y);

        for (k = FILTER_ORDER_DEF - 1; k > 0; k--)
        begin
            setpoint_hist[k] = setpoint_hist[k - 1];
            filtered_hist[k] = filtered_hist[k - 1];
        end
        setpoint_hist[0] = sp[SP_W-1:0];
        filtered_hist[0] = y[Y_W-1:0];

        // Integer part, truncated towards zero, clamped to the counter period.
        ipart = y / (longint'(1) <<< FRAC_W);
        if (ipart < 0)
            ipart = 0;
        if (ipart > COUNTER_PERIOD_DEF)
            ipart = COUNTER_PERIOD_DEF;
        return ipart[PULSE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input int expected_val,
                                   input int got);
        $display("%0t ns: %s: expected %0d, got %0d", $time, what, expected_val, got);
        mismatch_count++;
    endtask

    // Presents one angle after a random gap and waits until it is taken.
    task automatic send_angle(input logic signed [ANGLE_W-1:0] angle);
        int gap;
        gap = pick_gap(gaps_on);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(TDATA_W - ANGLE_W){1'b0}}, angle};
        do
            @(posedge clk);
        while (!s_tready);
        pulse_expected_q.push_back(next_pulse_compare(angle));
    endtask

    // Stops sending and waits until every expected word has come back.
    task automatic drain_pulses();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pulse_expected_q.size() != 0);
    endtask

    // One register write; the caller lowers the enable after the last one.
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [COEF_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_PULSE_MIN:     min_setting = val[PULSE_W-1:0];
            REG_PULSE_MAX:     max_setting = val[PULSE_W-1:0];
            REG_COEF_B_OUTER:  b_outer     = val;
            REG_COEF_B_INNER:  b_inner     = val;
            REG_COEF_A_FIRST:  a_first     = val;
            REG_COEF_A_SECOND: a_second    = val;
            REG_COEF_A_THIRD:  a_third     = val;
            default:           ;
        endcase
    endtask

    task automatic set_mapping(input logic [COEF_W-1:0] lo, input logic [COEF_W-1:0] hi);
        drain_pulses();
        write_reg(REG_PULSE_MIN, lo);
        write_reg(REG_PULSE_MAX, hi);
        cfg_we <= 1'b0;
    endtask

    task automatic set_coefficients(input logic [COEF_W-1:0] bo, input logic [COEF_W-1:0] bi,
                                    input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                                    input logic [COEF_W-1:0] a3);
        drain_pulses();
        write_reg(REG_COEF_B_OUTER, bo);
        write_reg(REG_COEF_B_INNER, bi);
        write_reg(REG_COEF_A_FIRST, a1);
        write_reg(REG_COEF_A_SECOND, a2);
        write_reg(REG_COEF_A_THIRD, a3);
        cfg_we <= 1'b0;
    endtask

    // Settings after reset: centre, both ends and the widest 9 bit angles.
    task automatic test_reset_defaults();
        send_angle(0);
        send_angle(180);
        send_angle(180);
        send_angle(-180);
        send_angle(255);
        send_angle(-256);
        send_angle(90);
    endtask

    // Full swing, reversed slope, set point saturation and a stray index.
    task automatic test_mapping_extremes();
        set_mapping('0, COEF_W'(COUNTER_PERIOD_DEF));
        drain_pulses();
        write_reg(REG_UNUSED, 20'hFFFFF);
        cfg_we <= 1'b0;
        send_angle(180);
        send_angle(180);
        send_angle(-1);
        // Upper data bits of a 16 bit register are dropped.
        set_mapping(20'hFFFFF, '0);
        send_angle(-256);
        send_angle(-256);
        send_angle(255);
        set_mapping(COEF_W'(PULSE_MIN_RST), COEF_W'(PULSE_MIN_RST));
        send_angle(1);
    endtask

    // Coefficient extremes drive the output into both clamps.
    task automatic test_coefficient_extremes();
        set_coefficients(20'h7FFFF, 20'h7FFFF, '0, '0, '0);
        send_angle(180);
        send_angle(180);
        set_coefficients(20'h80000, 20'h80000, 20'h80000, 20'h7FFFF, 20'h80000);
        send_angle(180);
        send_angle(-256);
        send_angle(255);
        set_coefficients(COEF_B_OUTER_RST, COEF_B_INNER_RST, COEF_A_FIRST_RST,
                         COEF_A_SECOND_RST, COEF_A_THIRD_RST);
        set_mapping(COEF_W'(PULSE_MIN_RST), COEF_W'(PULSE_MAX_RST));
        send_angle(45);
        send_angle(45);
    endtask

    // Set point moves, each held for one to eight words, under several mappings.
    task automatic test_setpoint_moves();
        logic signed [ANGLE_W-1:0] target;
        int phase, hold, sent;
        for (phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0:       set_mapping('0, COEF_W'(COUNTER_PERIOD_DEF));
                1:       set_mapping(COEF_W'(COUNTER_PERIOD_DEF), '0);
                default: set_mapping(COEF_W'($urandom_range(0, 65535)),
                                     COEF_W'($urandom_range(0, 65535)));
            endcase
            // One phase runs back to back with no gaps or stalls.
            gaps_on   = (phase != 2);
            stalls_on = (phase != 2);
            sent = 0;
            while (sent < 80)
            begin
                target = pick_angle();
                hold   = $urandom_range(1, 8);
                repeat (hold)
                begin
                    send_angle(target);
                    sent++;
                end
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Coefficients near the defaults alternate with arbitrary ones.
    task automatic test_random_coefficients();
        int phase, n;
        for (phase = 0; phase < 6; phase++)
        begin
            set_mapping(COEF_W'($urandom_range(0, 65535)), COEF_W'($urandom_range(0, 65535)));
            if (phase % 2 == 0)
                set_coefficients(
                    COEF_W'(int'(COEF_B_OUTER_RST) + int'($urandom_range(0, 200)) - 100),
                    COEF_W'(int'(COEF_B_INNER_RST) + int'($urandom_range(0, 200)) - 100),
                    COEF_W'(int'(COEF_A_FIRST_RST) + int'($urandom_range(0, 200)) - 100),
                    COEF_W'(int'(COEF_A_SECOND_RST) + int'($urandom_range(0, 200)) - 100),
                    COEF_W'(int'(COEF_A_THIRD_RST) + int'($urandom_range(0, 200)) - 100));
            else
                set_coefficients(COEF_W'($urandom), COEF_W'($urandom), COEF_W'($urandom),
                                 COEF_W'($urandom), COEF_W'($urandom));
            for (n = 0; n < 22; n++)
                send_angle(pick_angle());
        end
    endtask

    // Output side: random back-pressure, mostly short stalls.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_tready <= 1'b1;
            if (stalls_on && $urandom_range(0, 99) < 8)
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                         : $urandom_range(1, 4);
        end
    end

    // Each word leaving the block is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pulse_expected_q.size() == 0)
                report_mismatch("pulse_compare with none pending", -1, int'(m_tdata));
            else if (m_tdata !== pulse_expected_q[0])
                report_mismatch("pulse_compare", int'(pulse_expected_q.pop_front()),
                                int'(m_tdata));
            else
                void'(pulse_expected_q.pop_front());
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        foreach (setpoint_hist[k])
        begin
            setpoint_hist[k] = '0;
            filtered_hist[k] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_mapping_extremes();
        test_coefficient_extremes();
        test_setpoint_moves();
        test_random_coefficients();

        drain_pulses();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pulse_expected_q.size() != 0)
            report_mismatch("pulse_compare words missing", 0, pulse_expected_q.size());

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
